@@ rtl/address_window_translation_table_core_assert.svh @@
// Assertion macros for the address window translation table.
`ifndef ADDRESS_WINDOW_TRANSLATION_TABLE_CORE_ASSERT_SVH
`define ADDRESS_WINDOW_TRANSLATION_TABLE_CORE_ASSERT_SVH

// a condition implies a consequence in the same cycle
`define AWT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// a condition implies a consequence in the next cycle
`define AWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/awtt_pkg.sv @@
// ----------------------------------------------------------------------------
// awtt_pkg
// Shared types and codes of the address window translation table.
// ----------------------------------------------------------------------------
package awtt_pkg;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_FILL   = 3'd2,
    KIND_TOPHYS = 3'd3,
    KIND_TOCPU  = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LK_RD,    // lookup: issue read
    ST_LK_CHK,   // lookup: compare
    ST_ADD_FIND, // add: find insert position
    ST_ADD_CHK,
    ST_SH_RD,    // shift up: read entry i-1
    ST_SH_WR,    // shift up: write entry i
    ST_OV_RD,    // overlap pass: read entry k
    ST_OV_CHK,
    ST_DR_RD,    // shift down: read entry i+1
    ST_DR_WR,
    ST_FL_RD,    // fill: read entry z
    ST_FL_CHK,
    ST_FL_PRV,   // fill: read entry z-1
    ST_FL_PCHK,
    ST_FL_TAIL,  // fill: read last entry
    ST_FL_TCHK,
    ST_WR_NEW,   // write a pending entry after shift
    ST_DONE
  } state_t;

  // what to do once an entry has been opened
  typedef enum logic [1:0] {
    OP_NEW_WIN,
    OP_SPLIT,
    OP_GAP,
    OP_TAIL
  } open_op_t;

endpackage

@@ rtl/awtt_mem.sv @@
// ----------------------------------------------------------------------------
// awtt_mem
// Window store: one synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module awtt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    rdata <= ram[raddr];
  end
endmodule

@@ rtl/address_window_translation_table_core.sv @@
// ----------------------------------------------------------------------------
// address_window_translation_table_core
// Per-space sorted window tables with add/trim/split, gap fill and lookups.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid/in_ready, kind..lookup_address
// out     | output    | out_valid/out_ready, translated, hit, table_full,
//         |           | entry_count
//
// An item walks its space's table in a simple dual-port RAM (one write, one
// registered read port), each entry read being an address state, then a
// compare state. Adds and fills also shift entries, each shift a read state
// followed by a write state.
// Reset clears window counts; window RAM holds no reset.
// One item in flight; in_ready is held low until the result is taken or
// parked in the output register.
module address_window_translation_table_core #(
  parameter int MAX_WINDOWS = 16,
  parameter int NUM_SPACES  = 4,
  parameter int ADDR_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [1:0]  space,
  input  logic [31:0] window_cpu_start,
  input  logic [31:0] window_phys_start,
  input  logic [31:0] window_length,
  input  logic [31:0] fill_end,
  input  logic [31:0] lookup_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] translated,
  output logic        hit,
  output logic        table_full,
  output logic [4:0]  entry_count
);
  localparam int WB = $clog2(MAX_WINDOWS);        // entry index bits
  localparam int CB = $clog2(MAX_WINDOWS + 1);    // count bits
  localparam int SB = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
  localparam int AW = SB + WB;
  localparam int DW = 4 * ADDR_BITS;
  localparam int PASS_LIMIT = 4 * MAX_WINDOWS + 4;
  localparam int PB = $clog2(PASS_LIMIT + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef struct packed {
    addr_t cs;
    addr_t ce;
    addr_t ps;
    addr_t pe;
  } win_t;

  awtt_pkg::state_t state, state_next;

  // item registers
  logic [2:0]  r_kind;
  logic [SB-1:0] r_sp;
  logic        r_ok;               // space within range
  addr_t       r_a, r_ps, r_len, r_fend;
  logic [31:0] r_addr;

  logic [CB-1:0] cnt [NUM_SPACES];
  addr_t       send [NUM_SPACES];

  // working registers
  logic [CB-1:0] idx, idx_next;      // scan / shift index
  logic [CB-1:0] z, z_next;          // position of new window
  logic [CB-1:0] pos, pos_next;      // open position
  logic [CB-1:0] n, n_next;          // count of current space
  logic          full, full_next;
  logic          fnd, fnd_next;
  logic [31:0]   res, res_next;
  logic          chg, chg_next;
  logic [PB-1:0] pass, pass_next;
  win_t          nw, nw_next;        // window to write after opening
  win_t          prv, prv_next;      // held entry (add's new window)
  addr_t         expv, expv_next;
  awtt_pkg::open_op_t op, op_next;

  logic          ov_valid, ov_ready;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  win_t          wdata, rdata;
  logic [CB-1:0] ridx, widx;

  awtt_mem #(.DEPTH(1 << AW), .AW(AW), .DW(DW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign raddr = {r_sp, ridx[WB-1:0]};
  assign waddr = {r_sp, widx[WB-1:0]};

  function automatic addr_t amax(addr_t x, addr_t y);
    return (x > y) ? x : y;
  endfunction
  function automatic addr_t amin(addr_t x, addr_t y);
    return (x < y) ? x : y;
  endfunction

  // overlap of held new window (prv) and entry read (rdata)
  addr_t os, oe, dd;
  always_comb begin
    os = amax(prv.cs, rdata.cs);
    oe = amin(prv.ce, rdata.ce);
    dd = oe - os + addr_t'(1);
  end

  logic sp_ok;
  always_comb begin
    sp_ok = (32'(space) < 32'(NUM_SPACES));
  end

  // a result parked in the output register does not hold off the next item
  assign in_ready = (state == awtt_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next = idx; z_next = z; pos_next = pos; n_next = n;
    full_next = full; fnd_next = fnd; res_next = res; chg_next = chg;
    pass_next = pass; nw_next = nw; prv_next = prv; expv_next = expv;
    op_next = op;
    we = 1'b0; widx = idx; wdata = nw; ridx = idx;
    case (state)
      awtt_pkg::ST_IDLE: begin
        // started in the clocked block
      end
      awtt_pkg::ST_LK_RD: begin
        if (idx >= n) begin
          state_next = awtt_pkg::ST_DONE;
        end else begin
          state_next = awtt_pkg::ST_LK_CHK;
        end
      end
      awtt_pkg::ST_LK_CHK: begin
        if (r_kind == awtt_pkg::KIND_TOPHYS) begin
          if (r_a >= rdata.cs && r_a <= rdata.ce) begin
            fnd_next = 1'b1;
            res_next = 32'((r_a - rdata.cs) + rdata.ps);
          end
        end else begin
          if (r_a >= rdata.ps && r_a <= rdata.pe) begin
            fnd_next = 1'b1;
            res_next = 32'((r_a - rdata.ps) + rdata.cs);
          end
        end
        if ((r_kind == awtt_pkg::KIND_TOPHYS && r_a >= rdata.cs && r_a <= rdata.ce) ||
            (r_kind != awtt_pkg::KIND_TOPHYS && r_a >= rdata.ps && r_a <= rdata.pe)) begin
          state_next = awtt_pkg::ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
          ridx = idx + 1'b1;
          state_next = awtt_pkg::ST_LK_RD;
        end
      end
      awtt_pkg::ST_ADD_FIND: begin
        if (idx >= n) begin
          z_next = idx;
          state_next = awtt_pkg::ST_SH_RD;
          pos_next = idx;
          op_next = awtt_pkg::OP_NEW_WIN;
          idx_next = n;
          ridx = n - 1'b1;
          if (32'(n) >= 32'(MAX_WINDOWS)) begin
            full_next = 1'b1;
            state_next = awtt_pkg::ST_DONE;
          end
        end else begin
          state_next = awtt_pkg::ST_ADD_CHK;
        end
      end
      awtt_pkg::ST_ADD_CHK: begin
        if (rdata.cs >= r_a) begin
          z_next = idx;
          pos_next = idx;
          op_next = awtt_pkg::OP_NEW_WIN;
          idx_next = n;
          ridx = n - 1'b1;
          state_next = awtt_pkg::ST_SH_RD;
          if (32'(n) >= 32'(MAX_WINDOWS)) begin
            full_next = 1'b1;
            state_next = awtt_pkg::ST_DONE;
          end
        end else begin
          idx_next = idx + 1'b1;
          ridx = idx + 1'b1;
          state_next = awtt_pkg::ST_ADD_FIND;
        end
      end
      // open entry at pos: move entries pos..n-1 up by one (from the top)
      awtt_pkg::ST_SH_RD: begin
        ridx = idx - 1'b1;
        if (idx <= pos) begin
          state_next = awtt_pkg::ST_WR_NEW;
        end else begin
          state_next = awtt_pkg::ST_SH_WR;
        end
      end
      awtt_pkg::ST_SH_WR: begin
        we = 1'b1; widx = idx; wdata = rdata;
        idx_next = idx - 1'b1;
        ridx = idx - 2'd2;
        state_next = awtt_pkg::ST_SH_RD;
      end
      awtt_pkg::ST_WR_NEW: begin
        we = 1'b1; widx = pos; wdata = nw;
        n_next = n + 1'b1;
        case (op)
          awtt_pkg::OP_NEW_WIN: begin
            prv_next = nw;
            chg_next = 1'b0; pass_next = '0;
            idx_next = '0; ridx = '0;
            state_next = awtt_pkg::ST_OV_RD;
          end
          awtt_pkg::OP_SPLIT: begin
            // pass ends with change; start next pass
            pass_next = pass + 1'b1;
            idx_next = '0; ridx = '0; chg_next = 1'b0;
            if (32'(pass) + 1 >= PASS_LIMIT) begin
              state_next = awtt_pkg::ST_DONE;
            end else begin
              state_next = awtt_pkg::ST_OV_RD;
            end
          end
          awtt_pkg::OP_GAP: begin
            z_next = pos + 2'd2;
            idx_next = pos + 2'd2; ridx = pos + 2'd2;
            state_next = awtt_pkg::ST_FL_RD;
          end
          default: begin
            state_next = awtt_pkg::ST_DONE;
          end
        endcase
      end
      // overlap pass, entry idx against new window at z
      awtt_pkg::ST_OV_RD: begin
        if (idx >= n) begin
          // pass ended without change
          state_next = awtt_pkg::ST_DONE;
        end else if (idx == z) begin
          idx_next = idx + 1'b1; ridx = idx + 1'b1;
        end else begin
          state_next = awtt_pkg::ST_OV_CHK;
        end
      end
      awtt_pkg::ST_OV_CHK: begin
        if (os > oe) begin
          idx_next = idx + 1'b1; ridx = idx + 1'b1;
          state_next = awtt_pkg::ST_OV_RD;
        end else if (os == rdata.cs && oe == rdata.ce) begin
          // drop entry idx: shift down
          if (idx < z) begin
            z_next = z - 1'b1;
          end
          ridx = idx + 1'b1;
          state_next = awtt_pkg::ST_DR_RD;
        end else if (os == rdata.cs) begin
          we = 1'b1; widx = idx;
          wdata = rdata;
          wdata.cs = rdata.cs + dd;
          wdata.ps = rdata.ps + dd;
          idx_next = idx + 1'b1; ridx = idx + 1'b1;
          state_next = awtt_pkg::ST_OV_RD;
        end else if (oe == rdata.ce) begin
          we = 1'b1; widx = idx;
          wdata = rdata;
          wdata.ce = rdata.ce - dd;
          wdata.pe = rdata.pe - dd;
          idx_next = idx + 1'b1; ridx = idx + 1'b1;
          state_next = awtt_pkg::ST_OV_RD;
        end else begin
          // split: lower part in place, upper part after new window
          we = 1'b1; widx = idx;
          wdata = rdata;
          wdata.ce = rdata.ce - (rdata.ce - os + addr_t'(1));
          wdata.pe = rdata.pe - (rdata.ce - os + addr_t'(1));
          nw_next.cs = rdata.cs + (oe - rdata.cs + addr_t'(1));
          nw_next.ce = rdata.ce;
          nw_next.ps = rdata.ps + (oe - rdata.cs + addr_t'(1));
          nw_next.pe = rdata.pe;
          op_next = awtt_pkg::OP_SPLIT;
          pos_next = z + 1'b1;
          idx_next = n;
          if (32'(n) >= 32'(MAX_WINDOWS)) begin
            full_next = 1'b1;
            pass_next = pass + 1'b1;
            idx_next = '0; ridx = '0;
            if (32'(pass) + 1 >= PASS_LIMIT) begin
              state_next = awtt_pkg::ST_DONE;
            end else begin
              state_next = awtt_pkg::ST_OV_RD;
            end
          end else begin
            state_next = awtt_pkg::ST_SH_RD;
          end
        end
      end
      awtt_pkg::ST_DR_RD: begin
        ridx = idx + 1'b1;
        if (32'(idx) + 1 >= 32'(n)) begin
          n_next = n - 1'b1;
          pass_next = pass + 1'b1;
          idx_next = '0; ridx = '0;
          if (32'(pass) + 1 >= PASS_LIMIT) begin
            state_next = awtt_pkg::ST_DONE;
          end else begin
            state_next = awtt_pkg::ST_OV_RD;
          end
        end else begin
          state_next = awtt_pkg::ST_DR_WR;
        end
      end
      awtt_pkg::ST_DR_WR: begin
        we = 1'b1; widx = idx; wdata = rdata;
        idx_next = idx + 1'b1;
        ridx = idx + 2'd2;
        state_next = awtt_pkg::ST_DR_RD;
      end
      // fill walk
      awtt_pkg::ST_FL_RD: begin
        if (z >= n) begin
          if (n == '0) begin
            expv_next = r_a;
            nw_next = '{cs: r_a, ce: r_fend, ps: r_a, pe: r_fend};
            op_next = awtt_pkg::OP_TAIL;
            pos_next = '0; idx_next = '0;
            state_next = awtt_pkg::ST_SH_RD;
          end else begin
            ridx = n - 1'b1;
            state_next = awtt_pkg::ST_FL_TAIL;
          end
        end else if (z == '0) begin
          ridx = z;
          expv_next = r_a;
          state_next = awtt_pkg::ST_FL_CHK;
        end else begin
          ridx = z - 1'b1;
          state_next = awtt_pkg::ST_FL_PRV;
        end
      end
      awtt_pkg::ST_FL_PRV: begin
        ridx = z;
        expv_next = rdata.ce + addr_t'(1);
        state_next = awtt_pkg::ST_FL_CHK;
      end
      awtt_pkg::ST_FL_CHK: begin
        if (rdata.cs <= expv) begin
          z_next = z + 1'b1;
          state_next = awtt_pkg::ST_FL_RD;
        end else if (32'(n) >= 32'(MAX_WINDOWS)) begin
          full_next = 1'b1;
          z_next = z + 1'b1;
          state_next = awtt_pkg::ST_FL_RD;
        end else begin
          nw_next = '{cs: expv, ce: rdata.cs - addr_t'(1),
                      ps: expv, pe: rdata.cs - addr_t'(1)};
          op_next = awtt_pkg::OP_GAP;
          pos_next = z; idx_next = n;
          ridx = n - 1'b1;
          state_next = awtt_pkg::ST_SH_RD;
        end
      end
      awtt_pkg::ST_FL_TAIL: begin
        state_next = awtt_pkg::ST_FL_TCHK;
        ridx = n - 1'b1;
      end
      awtt_pkg::ST_FL_TCHK: begin
        if (rdata.ce < r_fend) begin
          if (32'(n) >= 32'(MAX_WINDOWS)) begin
            full_next = 1'b1;
            state_next = awtt_pkg::ST_DONE;
          end else begin
            nw_next = '{cs: rdata.ce + addr_t'(1), ce: r_fend,
                        ps: rdata.ce + addr_t'(1), pe: r_fend};
            op_next = awtt_pkg::OP_TAIL;
            pos_next = n; idx_next = n;
            state_next = awtt_pkg::ST_SH_RD;
          end
        end else begin
          state_next = awtt_pkg::ST_DONE;
        end
      end
      awtt_pkg::ST_DONE: begin
        if (ov_ready) begin
          state_next = awtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = awtt_pkg::ST_IDLE;
      end
    endcase
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= awtt_pkg::ST_IDLE;
      for (int i = 0; i < NUM_SPACES; i++) begin
        cnt[i]  <= '0;
        send[i] <= '0;
      end
    end else begin
      // an out-of-range space touches no table
      if (state != awtt_pkg::ST_IDLE && r_ok) begin
        cnt[r_sp] <= n_next;
        if (state == awtt_pkg::ST_DONE && r_kind == awtt_pkg::KIND_FILL) begin
          send[r_sp] <= r_fend;
        end
      end
      if (in_valid && in_ready && sp_ok) begin
        case (kind)
          awtt_pkg::KIND_CLEAR: begin
            cnt[SB'(space)]  <= '0;
            send[SB'(space)] <= '0;
            state <= awtt_pkg::ST_DONE;
          end
          awtt_pkg::KIND_ADD: begin
            state <= (ADDR_BITS'(window_length) == '0) ? awtt_pkg::ST_DONE
                                                       : awtt_pkg::ST_ADD_FIND;
          end
          awtt_pkg::KIND_FILL: state <= awtt_pkg::ST_FL_RD;
          awtt_pkg::KIND_TOPHYS, awtt_pkg::KIND_TOCPU: state <= awtt_pkg::ST_LK_RD;
          default: state <= awtt_pkg::ST_DONE;
        endcase
      end else if (in_valid && in_ready) begin
        state <= awtt_pkg::ST_DONE;
      end else begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_kind <= kind;
      r_sp   <= sp_ok ? SB'(space) : '0;
      r_ok   <= sp_ok;
      r_a    <= (kind == awtt_pkg::KIND_TOPHYS || kind == awtt_pkg::KIND_TOCPU)
                ? ADDR_BITS'(lookup_address) : ADDR_BITS'(window_cpu_start);
      r_ps   <= ADDR_BITS'(window_phys_start);
      r_len  <= ADDR_BITS'(window_length);
      r_fend <= ADDR_BITS'(fill_end);
      r_addr <= lookup_address;
      idx <= '0; z <= '0; pass <= '0; chg <= 1'b0;
      full <= 1'b0; fnd <= 1'b0; res <= lookup_address;
      n <= sp_ok ? (kind == awtt_pkg::KIND_CLEAR ? '0 : cnt[SB'(space)]) : '0;
      nw.cs <= ADDR_BITS'(window_cpu_start);
      nw.ce <= ADDR_BITS'(window_cpu_start) + ADDR_BITS'(window_length) - addr_t'(1);
      nw.ps <= ADDR_BITS'(window_phys_start);
      nw.pe <= ADDR_BITS'(window_phys_start) + ADDR_BITS'(window_length) - addr_t'(1);
    end else begin
      idx <= idx_next; z <= z_next; pos <= pos_next; n <= n_next;
      full <= full_next; fnd <= fnd_next; res <= res_next; chg <= chg_next;
      pass <= pass_next; nw <= nw_next; prv <= prv_next; expv <= expv_next;
      op <= op_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == awtt_pkg::ST_DONE && ov_ready) begin
        out_valid   <= 1'b1;
        translated  <= fnd ? res : r_addr;
        hit         <= fnd;
        table_full  <= full;
        entry_count <= 5'(n);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ov_ready = !out_valid || out_ready;
  assign ov_valid = out_valid;

  logic unused;
  assign unused = ^{r_ps, r_len, chg, ov_valid, send[0]};
endmodule

@@ rtl/awtt_checker.sv @@
// ----------------------------------------------------------------------------
// awtt_checker
// Port-level checks for the address window translation table.
// ----------------------------------------------------------------------------
`include "address_window_translation_table_core_assert.svh"
module awtt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       hit,
  input logic       table_full,
  input logic [4:0] entry_count
);
  `AWT_ASSERT_NEXT(a_one_busy, clk, rst, in_valid && in_ready, !in_ready)
  `AWT_ASSERT_IMP(a_hit_full, clk, rst, out_valid, !(hit && table_full))
  `AWT_ASSERT_IMP(a_cnt, clk, rst, out_valid, entry_count <= 5'd16)
  `AWT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

bind address_window_translation_table_core awtt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
  .table_full(table_full), .entry_count(entry_count)
);

@@ tb/address_window_translation_table_core_test.sv @@
// ----------------------------------------------------------------------------
// address_window_translation_table_core_test
// Drives clear, add, gap-fill and lookup items into every address space and
// checks each result against a typed-in answer or a cycle-free model of the
// window tables. A short directed table leads, then random traffic mostly in
// a small address region, so windows overlap, split and fill the tables.
// ----------------------------------------------------------------------------
module address_window_translation_table_core_test;

  localparam int N_WIN    = 16;
  localparam int N_SPACE  = 4;
  localparam int N_RANDOM = 2000;
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = awtt_pkg::KIND_CLEAR;
  logic [1:0]  space = '0;
  logic [31:0] window_cpu_start = '0;
  logic [31:0] window_phys_start = '0;
  logic [31:0] window_length = '0;
  logic [31:0] fill_end = '0;
  logic [31:0] lookup_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] translated;
  logic        hit;
  logic        table_full;
  logic [4:0]  entry_count;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  space;
    logic [31:0] cs;
    logic [31:0] ps;
    logic [31:0] len;
    logic [31:0] fend;
    logic [31:0] addr;
  } item_t;

  typedef struct packed {
    logic [31:0] translated;
    logic        hit;
    logic        full;
    logic [4:0]  count;
  } answer_t;

  // directed row: item, whether the answer is typed in, and that answer
  typedef struct packed {
    item_t   it;
    logic    typed;
    answer_t ans;
  } dir_row_t;

  address_window_translation_table_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Window table model: one sorted table per space
  // --------------------------------------------------------------------------
  logic [31:0] m_cs [N_SPACE][N_WIN];
  logic [31:0] m_ce [N_SPACE][N_WIN];
  logic [31:0] m_ps [N_SPACE][N_WIN];
  logic [31:0] m_pe [N_SPACE][N_WIN];
  int          m_cnt [N_SPACE];

  function automatic void copy_win(int s, int dst, int src);
    m_cs[s][dst] = m_cs[s][src];
    m_ce[s][dst] = m_ce[s][src];
    m_ps[s][dst] = m_ps[s][src];
    m_pe[s][dst] = m_pe[s][src];
  endfunction

  function automatic void put_win(int s, int i, logic [31:0] cs, logic [31:0] ce,
                                  logic [31:0] ps, logic [31:0] pe);
    m_cs[s][i] = cs;
    m_ce[s][i] = ce;
    m_ps[s][i] = ps;
    m_pe[s][i] = pe;
  endfunction

  function automatic bit make_room(int s, int pos);
    if (m_cnt[s] >= N_WIN || pos > m_cnt[s]) return 1'b0;
    for (int i = m_cnt[s]; i > pos; i--) copy_win(s, i, i - 1);
    put_win(s, pos, '0, '0, '0, '0);
    m_cnt[s]++;
    return 1'b1;
  endfunction

  function automatic void remove_win(int s, int pos);
    if (pos >= m_cnt[s]) return;
    for (int i = pos; i + 1 < m_cnt[s]; i++) copy_win(s, i, i + 1);
    m_cnt[s]--;
  endfunction

  // insert a window, then trim, split or delete whatever it overlaps
  function automatic bit insert_window(int s, logic [31:0] cs, logic [31:0] ps,
                                       logic [31:0] len);
    int z;
    int passes;
    bit full;
    bit change;
    logic [31:0] os, oe, d, scs, sce, sps, spe;
    full = 1'b0;
    passes = 0;
    if (len == 0) return 1'b0;
    for (z = 0; z < m_cnt[s]; z++)
      if (m_cs[s][z] >= cs) break;
    if (!make_room(s, z)) return 1'b1;
    put_win(s, z, cs, cs + (len - 1), ps, ps + (len - 1));
    do begin
      change = 1'b0;
      for (int k = 0; k < m_cnt[s]; k++) begin
        if (k == z) continue;
        os = (m_cs[s][z] > m_cs[s][k]) ? m_cs[s][z] : m_cs[s][k];
        oe = (m_ce[s][z] < m_ce[s][k]) ? m_ce[s][z] : m_ce[s][k];
        if (os > oe) continue;
        if (os == m_cs[s][k] && oe == m_ce[s][k]) begin
          remove_win(s, k);
          if (k < z) z--;
          change = 1'b1;
          break;
        end else if (os == m_cs[s][k]) begin
          d = oe - os + 1;
          m_cs[s][k] += d;
          m_ps[s][k] += d;
        end else if (oe == m_ce[s][k]) begin
          d = oe - os + 1;
          m_ce[s][k] -= d;
          m_pe[s][k] -= d;
        end else begin
          scs = m_cs[s][k];
          sce = m_ce[s][k];
          sps = m_ps[s][k];
          spe = m_pe[s][k];
          d = sce - os + 1;
          m_ce[s][k] = sce - d;
          m_pe[s][k] = spe - d;
          if (make_room(s, z + 1)) begin
            d = oe - scs + 1;
            put_win(s, z + 1, scs + d, sce, sps + d, spe);
          end else begin
            full = 1'b1;
          end
          change = 1'b1;
          break;
        end
      end
      passes++;
    end while (change && passes < 4 * N_WIN + 4);
    return full;
  endfunction

  function automatic bit fill_identity(int s, logic [31:0] cs, logic [31:0] ce);
    int z;
    int n;
    bit full;
    logic [31:0] gap_lo;
    z = 0;
    full = 1'b0;
    while (z < m_cnt[s]) begin
      gap_lo = (z != 0) ? m_ce[s][z - 1] + 1 : cs;
      if (m_cs[s][z] <= gap_lo) begin
        z++;
        continue;
      end
      if (!make_room(s, z)) begin
        full = 1'b1;
        z++;
        continue;
      end
      put_win(s, z, gap_lo, m_cs[s][z + 1] - 1, gap_lo, m_cs[s][z + 1] - 1);
      z += 2;
    end
    n = m_cnt[s];
    if (n == 0 || m_ce[s][n - 1] < ce) begin
      gap_lo = (n != 0) ? m_ce[s][n - 1] + 1 : cs;
      if (make_room(s, n)) put_win(s, n, gap_lo, ce, gap_lo, ce);
      else full = 1'b1;
    end
    return full;
  endfunction

  function automatic answer_t window_map_predict(item_t it);
    answer_t r;
    int s;
    bit to_phys;
    logic [31:0] lo, hi, other;
    s = int'(it.space);
    r = '{translated: it.addr, hit: 1'b0, full: 1'b0, count: '0};
    case (it.kind)
      awtt_pkg::KIND_CLEAR: m_cnt[s] = 0;
      awtt_pkg::KIND_ADD:   r.full = insert_window(s, it.cs, it.ps, it.len);
      awtt_pkg::KIND_FILL:  r.full = fill_identity(s, it.cs, it.fend);
      awtt_pkg::KIND_TOPHYS, awtt_pkg::KIND_TOCPU: begin
        to_phys = (it.kind == awtt_pkg::KIND_TOPHYS);
        for (int i = 0; i < m_cnt[s]; i++) begin
          lo    = to_phys ? m_cs[s][i] : m_ps[s][i];
          hi    = to_phys ? m_ce[s][i] : m_pe[s][i];
          other = to_phys ? m_ps[s][i] : m_cs[s][i];
          if (it.addr >= lo && it.addr <= hi) begin
            r.translated = it.addr - lo + other;
            r.hit = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = m_cnt[s][4:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed items: answers typed in where obvious, else from the model
  // --------------------------------------------------------------------------
  localparam int N_DIR = 20;
  dir_row_t dir_rows [N_DIR] = '{
    // empty tables miss and hand the address back
    '{'{awtt_pkg::KIND_TOPHYS, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h0, 1'b0, 1'b0, 5'd0}},
    '{'{awtt_pkg::KIND_TOCPU, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0}},
    // zero length adds nothing
    '{'{awtt_pkg::KIND_ADD, 2'd0, 32'h100, 32'h8000, 32'h0, 32'h0, 32'h55}, 1'b1,
      '{32'h55, 1'b0, 1'b0, 5'd0}},
    '{'{awtt_pkg::KIND_ADD, 2'd0, 32'h100, 32'h8000, 32'h100, 32'h0, 32'h0}, 1'b1,
      '{32'h0, 1'b0, 1'b0, 5'd1}},
    '{'{awtt_pkg::KIND_TOPHYS, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h180}, 1'b1,
      '{32'h8080, 1'b1, 1'b0, 5'd1}},
    '{'{awtt_pkg::KIND_TOCPU, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80FF}, 1'b1,
      '{32'h1FF, 1'b1, 1'b0, 5'd1}},
    // split in the middle, trims at both ends, full cover
    '{'{awtt_pkg::KIND_ADD, 2'd0, 32'h180, 32'h9000, 32'h10, 32'h0, 32'h0}, 1'b0, '0},
    '{'{awtt_pkg::KIND_ADD, 2'd0, 32'hF0, 32'hA000, 32'h20, 32'h0, 32'h0}, 1'b0, '0},
    '{'{awtt_pkg::KIND_ADD, 2'd0, 32'h1F0, 32'hB000, 32'h20, 32'h0, 32'h0}, 1'b0, '0},
    '{'{awtt_pkg::KIND_TOPHYS, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h190}, 1'b0, '0},
    // single shared address at the edge counts as overlap
    '{'{awtt_pkg::KIND_ADD, 2'd0, 32'h20F, 32'hC000, 32'h1, 32'h0, 32'h0}, 1'b0, '0},
    '{'{awtt_pkg::KIND_FILL, 2'd0, 32'h0, 32'h0, 32'h0, 32'h2000, 32'h0}, 1'b0, '0},
    '{'{awtt_pkg::KIND_ADD, 2'd0, 32'h0, 32'h0, 32'h1000, 32'h0, 32'h0}, 1'b0, '0},
    // window that wraps past the top overlaps nothing
    '{'{awtt_pkg::KIND_ADD, 2'd1, 32'hFFFF_FFF0, 32'h0, 32'h20, 32'h0, 32'h0}, 1'b0, '0},
    '{'{awtt_pkg::KIND_ADD, 2'd1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
      1'b0, '0},
    '{'{awtt_pkg::KIND_TOCPU, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h5}, 1'b0, '0},
    '{'{awtt_pkg::KIND_FILL, 2'd2, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1,
      '{32'h0, 1'b0, 1'b0, 5'd1}},
    // spare kinds touch nothing and miss
    '{'{KIND_SPARE_FIRST, 2'd2, 32'h0, 32'h0, 32'h10, 32'h0, 32'h77}, 1'b1,
      '{32'h77, 1'b0, 1'b0, 5'd1}},
    '{'{KIND_SPARE_LAST, 2'd2, 32'h0, 32'h0, 32'h10, 32'h0, 32'h0}, 1'b1,
      '{32'h0, 1'b0, 1'b0, 5'd1}},
    '{'{awtt_pkg::KIND_CLEAR, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3}, 1'b1,
      '{32'h3, 1'b0, 1'b0, 5'd0}}
  };

  answer_t pending_answers[$];
  int      n_mismatch = 0;
  bit      sender_done = 1'b0;
  bit      hold_request = 1'b0;

  // mostly a small region so windows collide; now and then the full range
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 99) < 88) return $urandom_range(0, 63) * 16 + $urandom_range(0, 15);
    return $urandom;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.space = 2'($urandom_range(0, N_SPACE - 1));
    it.cs    = pick_addr();
    it.ps    = pick_addr();
    it.fend  = pick_addr();
    it.addr  = pick_addr();
    case ($urandom_range(0, 19))
      0:       it.len = '0;
      1:       it.len = $urandom;
      default: it.len = $urandom_range(1, 64);
    endcase
    if (sel < 4)       it.kind = awtt_pkg::KIND_CLEAR;
    else if (sel < 45) it.kind = awtt_pkg::KIND_ADD;
    else if (sel < 52) it.kind = awtt_pkg::KIND_FILL;
    else if (sel < 73) it.kind = awtt_pkg::KIND_TOPHYS;
    else if (sel < 94) it.kind = awtt_pkg::KIND_TOCPU;
    else               it.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    return it;
  endfunction

  // offer one item, starting at a rising edge, return at its accepting edge
  task automatic offer_item(item_t it, bit typed, answer_t ans);
    answer_t pred;
    kind              <= it.kind;
    space             <= it.space;
    window_cpu_start  <= it.cs;
    window_phys_start <= it.ps;
    window_length     <= it.len;
    fill_end          <= it.fend;
    lookup_address    <= it.addr;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = window_map_predict(it);
    pending_answers.push_back(typed ? ans : pred);
  endtask

  // ends a burst with a random gap; zero gaps keep valid high back to back
  int burst_left = 0;
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      offer_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].ans);
      pace_sender();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_request = 1'b1;
      offer_item(random_item(), 1'b0, '0);
      pace_sender();
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall patterns; one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int cyc;
    int mode;
    answer_t exp_ans;
    answer_t got;
    cyc = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{translated: translated, hit: hit, full: table_full, count: entry_count};
        if (pending_answers.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result item: %p", got);
        end else begin
          exp_ans = pending_answers.pop_front();
          if (got !== exp_ans) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: exp tr=%h hit=%b full=%b cnt=%0d, got tr=%h hit=%b full=%b cnt=%0d",
                       exp_ans.translated, exp_ans.hit, exp_ans.full, exp_ans.count,
                       got.translated, got.hit, got.full, got.count);
          end
        end
      end
      if (hold_request) begin
        // long hold-off so the block backs up and stalls its input
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        continue;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (cyc % 4 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // End of run
  // --------------------------------------------------------------------------
  initial begin
    wait (sender_done);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_mismatch == 0 && pending_answers.size() == 0) begin
      $display("[address_window_translation_table_core] OK");
    end else begin
      $display("[address_window_translation_table_core] ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[address_window_translation_table_core] ERROR");
    $finish;
  end

endmodule
